[rtl/chte_pkg.sv]
// ----------------------------------------------------------------------------
// chte_pkg
// Shared constants, codes and types of the chained hash table engine.
// ----------------------------------------------------------------------------
package chte_pkg;

  localparam int BUCKETS = 1024;
  localparam int NODES   = 1024;
  localparam int NREG    = 4;                    // hash coefficient registers
  localparam int COEF_W  = 10;
  localparam int CHUNK   = $clog2(BUCKETS);      // key chunk width
  localparam int BKT_W   = $clog2(BUCKETS);
  localparam int NODE_AW = $clog2(NODES);
  localparam int LNK_W   = NODE_AW + 1;          // node index or empty marker
  localparam int CNT_W   = NODE_AW + 1;
  localparam int KEY_W   = 32;
  localparam int VAL_W   = 32;
  localparam int IDX_W   = $clog2(NREG);

  localparam logic [LNK_W-1:0] NIL = LNK_W'(NODES);

  localparam logic [2:0] MODE_ADD    = 3'd0;
  localparam logic [2:0] MODE_FIND   = 3'd1;
  localparam logic [2:0] MODE_REMOVE = 3'd2;
  localparam logic [2:0] MODE_RMFRST = 3'd3;
  localparam logic [2:0] MODE_CLEAR  = 3'd4;

  localparam logic [1:0] STAT_OK   = 2'd0;
  localparam logic [1:0] STAT_MISS = 2'd1;
  localparam logic [1:0] STAT_FULL = 2'd2;

  typedef logic [NREG-1:0][COEF_W-1:0] coef_arr_t;

  localparam coef_arr_t COEF_RST = {10'd7, 10'd5, 10'd3, 10'd1};

  typedef struct packed {
    logic [KEY_W-1:0] key;
    logic [VAL_W-1:0] val;
    logic [LNK_W-1:0] nxt;
    logic [LNK_W-1:0] prv;
    logic [BKT_W-1:0] bkt;
  } node_t;

  // per-field write enables of the node memory
  typedef struct packed {
    logic key;
    logic val;
    logic nxt;
    logic prv;
    logic bkt;
  } node_wmask_t;

endpackage

[rtl/chte_hash.sv]
// ----------------------------------------------------------------------------
// chte_hash
// Iterative universal hash: one chunk times its coefficient per cycle.
// ----------------------------------------------------------------------------
module chte_hash import chte_pkg::*; (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             start,
  input  logic [KEY_W-1:0] key,
  input  coef_arr_t        coef,
  output logic             done,
  output logic [BKT_W-1:0] bucket
);

  logic             busy_r, busy_nxt;
  logic             done_r, done_nxt;
  logic [IDX_W-1:0] idx_r, idx_nxt;
  logic [BKT_W-1:0] acc_r, acc_nxt;
  logic [CHUNK-1:0] chunk;
  logic [CHUNK+COEF_W-1:0] prod;

  assign chunk = CHUNK'(key >> (32'(idx_r) * 32'(CHUNK)));
  assign prod  = (CHUNK+COEF_W)'(coef[idx_r]) * (CHUNK+COEF_W)'(chunk);

  always_comb begin
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    idx_nxt  = idx_r;
    acc_nxt  = acc_r;
    if (start) begin
      busy_nxt = 1'b1;
      idx_nxt  = '0;
      acc_nxt  = '0;
    end else if (busy_r) begin
      acc_nxt = acc_r + prod[BKT_W-1:0];   // sum mod bucket count
      idx_nxt = idx_r + IDX_W'(1);
      if (idx_r == IDX_W'(NREG-1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      idx_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      idx_r  <= idx_nxt;
    end
    acc_r <= acc_nxt;
  end

  assign done   = done_r;
  assign bucket = acc_r;

endmodule

[rtl/chained_hash_table_engine_unit.sv]
// ----------------------------------------------------------------------------
// chained_hash_table_engine_unit
// Multimap of 32-bit keys to 32-bit values, chained buckets in memory.
// ----------------------------------------------------------------------------
// channel | dir | tdata / data                         | tuser / index
// in_     | in  | [31:0] lookup_key, [63:32] entry_val | [2:0] mode
// out_    | out | [31:0] found_value, [42:32] count    | [1:0] status
// cfg_    | in  | cfg_data: 10-bit coefficient         | cfg_index 0..3
//
// Flow: hash (one chunk per cycle, then the bucket), then for find and remove
// a walk along the chain node by node. Removal patches both neighbour links;
// unless it was the last pool node, the last node then moves into the hole
// and is relinked. Remove-first scans bucket heads at one head per cycle.
// Clear-all sweeps the head memory. Reset: a clearing pass over the head
// memory; no item is taken until it ends. Config writes are always taken.
// Stalls: one item at a time; a finished result waits in the output
// register while the next item is taken.
// ----------------------------------------------------------------------------
module chained_hash_table_engine_unit import chte_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [63:0] in_tdata,    // [31:0] lookup_key, [63:32] entry_value
  input  logic [2:0]  in_tuser,    // [2:0] mode
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [47:0] out_tdata,   // [31:0] found_value, [42:32] entry_count
  output logic [1:0]  out_tuser,   // [1:0] status
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [9:0]  cfg_data
);

  typedef enum logic [3:0] {
    S_CLR, S_IDLE, S_HASH, S_HEAD, S_ALNK, S_FCHK, S_RSCAN, S_RLD,
    S_UNP, S_UNN, S_RDL, S_MOV, S_MP, S_MN, S_PUT
  } state_t;

  state_t             st_r, st_nxt;
  logic [2:0]         mode_r, mode_nxt;
  logic [KEY_W-1:0]   key_r, key_nxt;
  logic [VAL_W-1:0]   val_r, val_nxt;
  logic [BKT_W-1:0]   bkt_r, bkt_nxt;
  logic [NODE_AW-1:0] cur_r, cur_nxt;
  logic [LNK_W-1:0]   lnk_r, lnk_nxt;
  logic [CNT_W-1:0]   count_r, count_nxt;
  logic [BKT_W-1:0]   sw_r, sw_nxt;
  logic [BKT_W-1:0]   scan_r, scan_nxt;
  logic               chk_r, chk_nxt;
  logic               clr_op_r, clr_op_nxt;
  node_t              rm_r, rm_nxt;
  node_t              mv_r, mv_nxt;
  logic [1:0]         res_stat_r, res_stat_nxt;
  logic [VAL_W-1:0]   res_val_r, res_val_nxt;
  logic               out_valid_r, out_valid_nxt;
  logic [1:0]         out_stat_r, out_stat_nxt;
  logic [VAL_W-1:0]   out_val_r, out_val_nxt;
  logic [CNT_W-1:0]   out_cnt_r, out_cnt_nxt;
  coef_arr_t          coef_r, coef_nxt;

  // head memory
  logic [LNK_W-1:0] hd_mem [BUCKETS];
  logic             hd_we;
  logic [BKT_W-1:0] hd_waddr, hd_raddr;
  logic [LNK_W-1:0] hd_wdata, hd_rdata;

  // node memory, one word per node with field write enables
  node_t              nd_mem [NODES];
  node_wmask_t        nd_we;
  logic [NODE_AW-1:0] nd_waddr, nd_raddr;
  node_t              nd_wdata, nd_rdata;

  logic               in_acc;
  logic               h_start, h_done;
  logic [BKT_W-1:0]   h_bucket;
  logic [NODE_AW-1:0] last;

  assign in_tready = (st_r == S_IDLE);
  assign in_acc    = in_tvalid && in_tready;
  assign cfg_ready = 1'b1;
  assign last      = NODE_AW'(count_r - CNT_W'(1));
  assign h_start   = in_acc && (in_tuser == MODE_ADD || in_tuser == MODE_FIND ||
                                in_tuser == MODE_REMOVE);

  // hash works on the key held since the item was taken
  chte_hash u_hash (
    .clk    (clk),
    .rst_n  (rst_n),
    .start  (h_start),
    .key    (key_r),
    .coef   (coef_r),
    .done   (h_done),
    .bucket (h_bucket)
  );

  always_ff @(posedge clk) begin
    if (hd_we) begin
      hd_mem[hd_waddr] <= hd_wdata;
    end
    hd_rdata <= hd_mem[hd_raddr];
  end

  always_ff @(posedge clk) begin
    if (nd_we.key) nd_mem[nd_waddr].key <= nd_wdata.key;
    if (nd_we.val) nd_mem[nd_waddr].val <= nd_wdata.val;
    if (nd_we.nxt) nd_mem[nd_waddr].nxt <= nd_wdata.nxt;
    if (nd_we.prv) nd_mem[nd_waddr].prv <= nd_wdata.prv;
    if (nd_we.bkt) nd_mem[nd_waddr].bkt <= nd_wdata.bkt;
    nd_rdata <= nd_mem[nd_raddr];
  end

  always_comb begin
    st_nxt       = st_r;
    mode_nxt     = mode_r;
    key_nxt      = key_r;
    val_nxt      = val_r;
    bkt_nxt      = bkt_r;
    cur_nxt      = cur_r;
    lnk_nxt      = lnk_r;
    count_nxt    = count_r;
    sw_nxt       = sw_r;
    scan_nxt     = scan_r;
    chk_nxt      = chk_r;
    clr_op_nxt   = clr_op_r;
    rm_nxt       = rm_r;
    mv_nxt       = mv_r;
    res_stat_nxt = res_stat_r;
    res_val_nxt  = res_val_r;
    out_valid_nxt = out_valid_r && !out_tready;
    out_stat_nxt = out_stat_r;
    out_val_nxt  = out_val_r;
    out_cnt_nxt  = out_cnt_r;
    coef_nxt     = coef_r;
    hd_we        = 1'b0;
    hd_waddr     = '0;
    hd_wdata     = NIL;
    hd_raddr     = '0;
    nd_we        = '0;
    nd_waddr     = '0;
    nd_wdata     = '0;
    nd_raddr     = '0;

    if (cfg_valid) begin
      coef_nxt[cfg_index] = cfg_data;
    end

    unique case (st_r)
      S_CLR: begin
        hd_we    = 1'b1;
        hd_waddr = sw_r;
        hd_wdata = NIL;
        sw_nxt   = sw_r + BKT_W'(1);
        if (sw_r == BKT_W'(BUCKETS-1)) begin
          count_nxt    = '0;
          res_stat_nxt = STAT_OK;
          res_val_nxt  = '0;
          st_nxt       = clr_op_r ? S_PUT : S_IDLE;
        end
      end

      S_IDLE: begin
        if (in_acc) begin
          mode_nxt     = in_tuser;
          key_nxt      = in_tdata[31:0];
          val_nxt      = in_tdata[63:32];
          res_val_nxt  = '0;
          res_stat_nxt = STAT_MISS;
          unique case (in_tuser)
            MODE_ADD: begin
              if (count_r == CNT_W'(NODES)) begin
                res_stat_nxt = STAT_FULL;
                st_nxt       = S_PUT;
              end else begin
                st_nxt = S_HASH;
              end
            end
            MODE_FIND, MODE_REMOVE: st_nxt = S_HASH;
            MODE_RMFRST: begin
              scan_nxt = '0;
              chk_nxt  = 1'b0;
              st_nxt   = (count_r == '0) ? S_PUT : S_RSCAN;
            end
            MODE_CLEAR: begin
              sw_nxt     = '0;
              clr_op_nxt = 1'b1;
              st_nxt     = S_CLR;
            end
            default: st_nxt = S_PUT;
          endcase
        end
      end

      S_HASH: begin
        hd_raddr = h_bucket;
        if (h_done) begin
          bkt_nxt = h_bucket;
          st_nxt  = S_HEAD;
        end
      end

      S_HEAD: begin
        if (mode_r == MODE_ADD) begin
          // new node at the pool end, pushed at the chain head
          nd_we    = '1;
          nd_waddr = count_r[NODE_AW-1:0];
          nd_wdata = '{key: key_r, val: val_r, nxt: hd_rdata, prv: NIL, bkt: bkt_r};
          hd_we    = 1'b1;
          hd_waddr = bkt_r;
          hd_wdata = count_r;
          cur_nxt  = count_r[NODE_AW-1:0];
          lnk_nxt  = hd_rdata;
          count_nxt    = count_r + CNT_W'(1);
          res_stat_nxt = STAT_OK;
          st_nxt   = (hd_rdata == NIL) ? S_PUT : S_ALNK;
        end else if (hd_rdata == NIL) begin
          st_nxt = S_PUT;
        end else begin
          nd_raddr = hd_rdata[NODE_AW-1:0];
          cur_nxt  = hd_rdata[NODE_AW-1:0];
          st_nxt   = S_FCHK;
        end
      end

      S_ALNK: begin
        nd_we.prv    = 1'b1;
        nd_waddr     = lnk_r[NODE_AW-1:0];
        nd_wdata.prv = {1'b0, cur_r};
        st_nxt       = S_PUT;
      end

      S_FCHK: begin
        if (nd_rdata.key == key_r) begin
          if (mode_r == MODE_FIND) begin
            res_stat_nxt = STAT_OK;
            res_val_nxt  = nd_rdata.val;
            st_nxt       = S_PUT;
          end else begin
            rm_nxt = nd_rdata;
            st_nxt = S_UNP;
          end
        end else if (nd_rdata.nxt == NIL) begin
          st_nxt = S_PUT;
        end else begin
          nd_raddr = nd_rdata.nxt[NODE_AW-1:0];
          cur_nxt  = nd_rdata.nxt[NODE_AW-1:0];
        end
      end

      S_RSCAN: begin
        // one head read per cycle; the check uses the registered head data, with chk_r marking it valid
        hd_raddr = scan_r;
        scan_nxt = scan_r + BKT_W'(1);
        chk_nxt  = 1'b1;
        if (chk_r && hd_rdata != NIL) begin
          nd_raddr = hd_rdata[NODE_AW-1:0];
          cur_nxt  = hd_rdata[NODE_AW-1:0];
          st_nxt   = S_RLD;
        end
      end

      S_RLD: begin
        rm_nxt = nd_rdata;
        st_nxt = S_UNP;
      end

      S_UNP: begin
        if (rm_r.prv == NIL) begin
          hd_we    = 1'b1;
          hd_waddr = rm_r.bkt;
          hd_wdata = rm_r.nxt;
        end else begin
          nd_we.nxt    = 1'b1;
          nd_waddr     = rm_r.prv[NODE_AW-1:0];
          nd_wdata.nxt = rm_r.nxt;
        end
        st_nxt = S_UNN;
      end

      S_UNN: begin
        if (rm_r.nxt != NIL) begin
          nd_we.prv    = 1'b1;
          nd_waddr     = rm_r.nxt[NODE_AW-1:0];
          nd_wdata.prv = rm_r.prv;
        end
        res_stat_nxt = STAT_OK;
        res_val_nxt  = rm_r.val;
        if (cur_r == last) begin
          count_nxt = count_r - CNT_W'(1);
          st_nxt    = S_PUT;
        end else begin
          st_nxt = S_RDL;
        end
      end

      S_RDL: begin
        nd_raddr = last;
        st_nxt   = S_MOV;
      end

      S_MOV: begin
        // last node fills the hole
        mv_nxt   = nd_rdata;
        nd_we    = '1;
        nd_waddr = cur_r;
        nd_wdata = nd_rdata;
        st_nxt   = S_MP;
      end

      S_MP: begin
        if (mv_r.prv == NIL) begin
          hd_we    = 1'b1;
          hd_waddr = mv_r.bkt;
          hd_wdata = {1'b0, cur_r};
        end else begin
          nd_we.nxt    = 1'b1;
          nd_waddr     = mv_r.prv[NODE_AW-1:0];
          nd_wdata.nxt = {1'b0, cur_r};
        end
        st_nxt = S_MN;
      end

      S_MN: begin
        if (mv_r.nxt != NIL) begin
          nd_we.prv    = 1'b1;
          nd_waddr     = mv_r.nxt[NODE_AW-1:0];
          nd_wdata.prv = {1'b0, cur_r};
        end
        count_nxt = count_r - CNT_W'(1);
        st_nxt    = S_PUT;
      end

      S_PUT: begin
        if (!out_valid_r || out_tready) begin
          out_valid_nxt = 1'b1;
          out_stat_nxt  = res_stat_r;
          out_val_nxt   = res_val_r;
          out_cnt_nxt   = count_r;
          st_nxt        = S_IDLE;
        end
      end

      default: st_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r        <= S_CLR;
      sw_r        <= '0;
      clr_op_r    <= 1'b0;
      count_r     <= '0;
      chk_r       <= 1'b0;
      out_valid_r <= 1'b0;
      coef_r      <= COEF_RST;
    end else begin
      st_r        <= st_nxt;
      sw_r        <= sw_nxt;
      clr_op_r    <= clr_op_nxt;
      count_r     <= count_nxt;
      chk_r       <= chk_nxt;
      out_valid_r <= out_valid_nxt;
      coef_r      <= coef_nxt;
    end
    mode_r     <= mode_nxt;
    key_r      <= key_nxt;
    val_r      <= val_nxt;
    bkt_r      <= bkt_nxt;
    cur_r      <= cur_nxt;
    lnk_r      <= lnk_nxt;
    scan_r     <= scan_nxt;
    rm_r       <= rm_nxt;
    mv_r       <= mv_nxt;
    res_stat_r <= res_stat_nxt;
    res_val_r  <= res_val_nxt;
    out_stat_r <= out_stat_nxt;
    out_val_r  <= out_val_nxt;
    out_cnt_r  <= out_cnt_nxt;
  end

  assign out_tvalid = out_valid_r;
  assign out_tuser  = out_stat_r;
  assign out_tdata  = {5'b0, out_cnt_r, out_val_r};

endmodule

[rtl/chte_chk.sv]
// ----------------------------------------------------------------------------
// chte_chk
// Port-level checks of the chained hash table engine, bound to the top.
// ----------------------------------------------------------------------------
module chte_chk (
  input logic        clk,
  input logic        rst_n,
  input logic        in_tvalid,
  input logic        in_tready,
  input logic        out_tvalid,
  input logic        out_tready,
  input logic [47:0] out_tdata,
  input logic [1:0]  out_tuser
);

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("result changed while stalled");

  a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> !in_tready)
    else $error("item taken while one is in progress");

  a_miss_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser != 2'd0 |-> out_tdata[31:0] == 32'd0)
    else $error("value on a miss or full result");

  a_full_count: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser == 2'd2 |-> out_tdata[42:32] == 11'd1024)
    else $error("full status with pool not full");

  a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> out_tdata[42:32] <= 11'd1024)
    else $error("entry count out of range");

endmodule

bind chained_hash_table_engine_unit chte_chk u_chte_chk (.*);

[bench/tb_chained_hash_table_engine_unit.sv]
// ----------------------------------------------------------------------------
// tb_chained_hash_table_engine_unit
// Drives add, find, remove, remove-first and clear items into the hash table
// engine, predicts every result with a behavioural table, and checks status,
// found value and entry count in order under several idling phases.
// ----------------------------------------------------------------------------
module tb_chained_hash_table_engine_unit;
  import chte_pkg::*;

  // behavioural hash table; keeps its own coefficients and node pool
  class table_scoreboard;
    logic [COEF_W-1:0]  coef [NREG];
    logic [LNK_W-1:0]   heads [BUCKETS];
    logic [KEY_W-1:0]   keys [NODES];
    logic [VAL_W-1:0]   vals [NODES];
    logic [LNK_W-1:0]   nxt [NODES];
    logic [LNK_W-1:0]   prv [NODES];
    logic [BKT_W-1:0]   bkt [NODES];
    logic [CNT_W-1:0]   used;
    logic [44:0]        pending [$];   // {status, count, value}
    int                 errors;
    int                 checked;

    function new();
      coef[0] = 1; coef[1] = 3; coef[2] = 5; coef[3] = 7;
      foreach (heads[i]) heads[i] = NIL;
      used = 0;
      errors = 0;
      checked = 0;
    endfunction

    function logic [BKT_W-1:0] bucket_of(logic [KEY_W-1:0] k);
      logic [31:0] sum;
      sum = 0;
      for (int i = 0; i < NREG; i++)
        if (CHUNK * i < 32) sum += 32'(coef[i]) * 32'((k >> (CHUNK * i)) & 32'h3ff);
      return sum[BKT_W-1:0];
    endfunction

    function void link_to(logic [LNK_W-1:0] p, logic [BKT_W-1:0] b, logic [LNK_W-1:0] t);
      if (p >= NIL) heads[b] = t;
      else nxt[p] = t;
    endfunction

    function logic [VAL_W-1:0] unlink(logic [LNK_W-1:0] n);
      logic [VAL_W-1:0] v;
      logic [LNK_W-1:0] last;
      v = vals[n];
      link_to(prv[n], bkt[n], nxt[n]);
      if (nxt[n] < NIL) prv[nxt[n]] = prv[n];
      last = used - 1;
      // last node fills the hole
      if (n != last) begin
        keys[n] = keys[last]; vals[n] = vals[last];
        nxt[n] = nxt[last]; prv[n] = prv[last]; bkt[n] = bkt[last];
        link_to(prv[n], bkt[n], n);
        if (nxt[n] < NIL) prv[nxt[n]] = n;
      end
      used--;
      return v;
    endfunction

    function logic [LNK_W-1:0] lookup(logic [KEY_W-1:0] k);
      logic [LNK_W-1:0] n;
      n = heads[bucket_of(k)];
      for (int s = 0; s < NODES && n < NIL; s++) begin
        if (keys[n] == k) return n;
        n = nxt[n];
      end
      return NIL;
    endfunction

    function void note_item(logic [2:0] mode, logic [KEY_W-1:0] k, logic [VAL_W-1:0] v);
      logic [1:0] st;
      logic [VAL_W-1:0] fv;
      logic [LNK_W-1:0] n;
      logic [BKT_W-1:0] b;
      st = STAT_MISS;
      fv = 0;
      case (mode)
        MODE_ADD: begin
          if (used >= NODES) st = STAT_FULL;
          else begin
            b = bucket_of(k);
            n = used;
            keys[n] = k; vals[n] = v; bkt[n] = b;
            prv[n] = NIL; nxt[n] = heads[b];
            if (heads[b] < NIL) prv[heads[b]] = n;
            heads[b] = n;
            used++;
            st = STAT_OK;
          end
        end
        MODE_FIND: begin
          n = lookup(k);
          if (n < NIL) begin st = STAT_OK; fv = vals[n]; end
        end
        MODE_REMOVE: begin
          n = lookup(k);
          if (n < NIL) begin st = STAT_OK; fv = unlink(n); end
        end
        MODE_RMFRST: begin
          for (int i = 0; i < BUCKETS; i++)
            if (heads[i] < NIL) begin
              fv = unlink(heads[i]);
              st = STAT_OK;
              break;
            end
        end
        MODE_CLEAR: begin
          foreach (heads[i]) heads[i] = NIL;
          used = 0;
          st = STAT_OK;
        end
        default: ;
      endcase
      pending.push_back({st, used, fv});
    endfunction

    function void check_result(logic [1:0] st, logic [47:0] d);
      logic [44:0] e;
      if (pending.size() == 0) begin
        $display("%0t: unexpected result status %0d data %h", $time, st, d);
        errors++;
        return;
      end
      e = pending.pop_front();
      checked++;
      if (st !== e[44:43]) begin
        $display("%0t: status exp %0d got %0d", $time, e[44:43], st); errors++;
      end
      if (d[31:0] !== e[31:0]) begin
        $display("%0t: value exp %h got %h", $time, e[31:0], d[31:0]); errors++;
      end
      if (d[42:32] !== e[42:32]) begin
        $display("%0t: count exp %0d got %0d", $time, e[42:32], d[42:32]); errors++;
      end
      if (d[47:43] !== 5'd0) begin
        $display("%0t: pad exp 0 got %h", $time, d[47:43]); errors++;
      end
    endfunction
  endclass

  localparam int STALL_LIMIT = 20000;   // covers clear sweep and reset pass

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [63:0] in_tdata = '0;   // [31:0] lookup_key, [63:32] entry_value
  logic [2:0]  in_tuser = '0;   // [2:0] mode
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [47:0] out_tdata;       // [31:0] found_value, [42:32] entry_count
  logic [1:0]  out_tuser;       // [1:0] status
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [1:0]  cfg_index = '0;
  logic [9:0]  cfg_data = '0;

  table_scoreboard sb = new();
  int send_idle_pct = 0;        // sender idle chance per cycle
  int recv_stall_pct = 0;       // receiver stall chance per cycle
  int idle_cycles = 0;          // watchdog count
  int n_items = 0;
  logic [KEY_W-1:0] key_pool [16];   // small key set so hits and chains happen

  chained_hash_table_engine_unit i_dut (.*);

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // result sampling at the rising edge
  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) sb.check_result(out_tuser, out_tdata);
  end

  // receiver stalls, changed at the falling edge
  always @(negedge clk) begin
    out_tready <= ($urandom_range(99) >= recv_stall_pct);
  end

  // watchdog: cycles with nothing accepted on any channel
  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready) || (cfg_valid && cfg_ready))
      idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles > STALL_LIMIT) begin
      $display("%0t: watchdog expired, %0d results pending", $time, sb.pending.size());
      $display("tb_chained_hash_table_engine_unit: errors");
      $finish;
    end
  end

  // one item, with a random idle gap in front; driven at the falling edge
  task automatic send_item(logic [2:0] mode, logic [31:0] k, logic [31:0] v);
    while ($urandom_range(99) < send_idle_pct) @(negedge clk);
    in_tvalid = 1'b1;
    in_tuser  = mode;
    in_tdata  = {v, k};
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    sb.note_item(mode, k, v);
    n_items++;
    @(negedge clk);
    in_tvalid = 1'b0;
  endtask

  task automatic write_coef(logic [1:0] idx, logic [9:0] d);
    cfg_valid = 1'b1;
    cfg_index = idx;
    cfg_data  = d;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    sb.coef[idx] = d;
    @(negedge clk);
    cfg_valid = 1'b0;
  endtask

  // drain then let any trailing work settle before a register write
  task automatic wait_idle();
    while (sb.pending.size() != 0) @(negedge clk);
    repeat (40) @(negedge clk);
  endtask

  task automatic random_item();
    int r;
    logic [31:0] k;
    r = $urandom_range(99);
    k = ($urandom_range(3) == 0) ? $urandom() : key_pool[$urandom_range(15)];
    if (r < 40) send_item(MODE_ADD, k, $urandom());
    else if (r < 65) send_item(MODE_FIND, k, $urandom());
    else if (r < 85) send_item(MODE_REMOVE, k, $urandom());
    else if (r < 96) send_item(MODE_RMFRST, $urandom(), $urandom());
    else if (r < 98) send_item(3'($urandom_range(7, 5)), $urandom(), $urandom());
    else send_item(MODE_CLEAR, $urandom(), $urandom());
  endtask

  // pool fill past capacity with all-zero coefficients (one long chain at bucket 0
  // would be slow), so use reset coefficients and random keys
  task automatic send_pct_phase_fill();
    for (int i = 0; i < NODES + 2; i++) send_item(MODE_ADD, $urandom(), $urandom());
    for (int i = 0; i < 20; i++) send_item(MODE_RMFRST, 32'h0, 32'h0);
    send_item(MODE_CLEAR, 32'h0, 32'h0);
  endtask

  initial begin
    foreach (key_pool[i]) key_pool[i] = $urandom();
    repeat (9) @(negedge clk);
    rst_n <= 1'b1;

    // directed: empty table cases, extremes, duplicates, bad modes
    send_item(MODE_FIND, 32'h0, 32'h0);
    send_item(MODE_REMOVE, 32'hffff_ffff, 32'h0);
    send_item(MODE_RMFRST, 32'h0, 32'h0);
    send_item(MODE_ADD, 32'h0, 32'hffff_ffff);
    send_item(MODE_ADD, 32'hffff_ffff, 32'h0);
    send_item(MODE_ADD, 32'h0, 32'h1234_5678);      // duplicate key, newest wins
    send_item(MODE_ADD, 32'h0000_0400, 32'haaaa_5555); // bucket 3 under reset coefs, apart from key 0
    send_item(MODE_FIND, 32'h0, 32'h0);
    send_item(MODE_REMOVE, 32'h0, 32'h0);
    send_item(MODE_FIND, 32'h0, 32'h0);
    send_item(MODE_FIND, 32'h0000_0400, 32'h0);
    send_item(3'd5, 32'h0, 32'h0);
    send_item(3'd7, 32'hffff_ffff, 32'hffff_ffff);
    send_item(MODE_RMFRST, 32'h0, 32'h0);
    send_item(MODE_REMOVE, 32'hffff_ffff, 32'h0);
    send_item(MODE_CLEAR, 32'h0, 32'h0);
    send_item(MODE_FIND, 32'h0000_0400, 32'h0);

    // fill the pool to overflow once, then remove 20 by remove-first and clear
    send_pct_phase_fill();

    // random phases: idling mixes and coefficient settings
    for (int ph = 0; ph < 8; ph++) begin
      wait_idle();
      case (ph % 4)
        0: begin write_coef(0, 10'd0); write_coef(1, 10'd0);
                 write_coef(2, 10'd0); write_coef(3, 10'd0); end
        1: begin write_coef(0, 10'd1023); write_coef(1, 10'd1023);
                 write_coef(2, 10'd1023); write_coef(3, 10'd1023); end
        default: for (int i = 0; i < NREG; i++) write_coef(2'(i), 10'($urandom()));
      endcase
      send_idle_pct  = (ph % 4 == 1) ? 50 : (ph % 4 == 3) ? 35 : 0;
      recv_stall_pct = (ph % 4 == 2) ? 50 : (ph % 4 == 3) ? 35 : 0;
      send_item(MODE_CLEAR, 32'h0, 32'h0);
      for (int i = 0; i < 110; i++) random_item();
    end

    send_idle_pct = 0;
    recv_stall_pct = 0;
    while (sb.pending.size() != 0) @(negedge clk);
    repeat (50) @(negedge clk);
    $display("%0d items sent, %0d results checked over all modes, coefficient",
             n_items, sb.checked);
    $display("extremes, pool overflow and four idling mixes");
    if (sb.errors == 0) $display("tb_chained_hash_table_engine_unit: clean");
    else $display("tb_chained_hash_table_engine_unit: errors");
    $finish;
  end

endmodule

[filelist.f]
rtl/chte_pkg.sv
rtl/chte_hash.sv
rtl/chained_hash_table_engine_unit.sv
rtl/chte_chk.sv
bench/tb_chained_hash_table_engine_unit.sv
